/* design/ppd_pkg.sv */
// Shared point pair distance constants: widths, register indexes, extent reset.
package ppd_pkg;

  // Result word width and configuration data width (widest register).
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_ON    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THREE_DIMS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_EXTENT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_EXTENT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Z_EXTENT   = 3'd4;

  // Extent after reset: 1.0 in Q16.16.
  localparam logic [31:0] EXTENT_RESET = 32'h0001_0000;

endpackage

/* design/ppd_axis.sv */
// Three-stage axis term: absolute difference, optional wrap, square.
module ppd_axis #(
  parameter int unsigned COORD_BITS = 31
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic                    wrap_on_i,
  input  logic [COORD_BITS-1:0]   extent_i,
  input  logic [COORD_BITS-1:0]   a_i,
  input  logic [COORD_BITS-1:0]   b_i,
  output logic [2*COORD_BITS-1:0] square_o
);

  logic [COORD_BITS-1:0]   diff_d, diff_q;
  logic [COORD_BITS-1:0]   mag_d, mag_q;
  logic [COORD_BITS-1:0]   rest, over;
  logic [2*COORD_BITS-1:0] sq_d, sq_q;

  always_comb begin
    diff_d = (a_i > b_i) ? (a_i - b_i) : (b_i - a_i);
  end

  // When the extent is below the difference, extent minus difference is negative
  // and hence the minimum; its magnitude is difference minus extent.
  always_comb begin
    rest  = extent_i - diff_q;
    over  = diff_q - extent_i;
    mag_d = diff_q;
    if (wrap_on_i) begin
      if (extent_i < diff_q) begin
        mag_d = over;
      end else if (rest < diff_q) begin
        mag_d = rest;
      end
    end
  end

  always_comb begin
    sq_d = mag_q * mag_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= diff_d;
      mag_q  <= mag_d;
      sq_q   <= sq_d;
    end
  end

  assign square_o = sq_q;

endmodule

/* design/ppd_sqrt.sv */
// Pipelined floor square root, one result bit resolved per register stage.
module ppd_sqrt #(
  parameter int unsigned SUM_W  = 64,
  parameter int unsigned ROOT_W = 32
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SUM_W-1:0]  sum_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [SUM_W-1:0]  rem_q  [ROOT_W-1];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int unsigned K = ROOT_W - 1 - j;

    logic [SUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SUM_W:0]    trial;
    logic              fits;

    if (j == 0) begin : g_first
      assign rem_in  = sum_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // The root so far only has bits above K, so adding bit K raises its square
    // by 2*root*2^K + 4^K.
    always_comb begin
      trial = ((SUM_W+1)'(root_in) << (K + 1)) | ((SUM_W+1)'(1) << (2 * K));
      fits  = ({1'b0, rem_in} >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[j] <= fits ? (root_in | (ROOT_W'(1) << K)) : root_in;
      end
    end

    // The last stage only needs the root, so it keeps no remainder.
    if (j < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= fits ? (rem_in - trial[SUM_W-1:0]) : rem_in;
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

/* design/point_pair_distance_core.sv */
// Stages: axis difference, wrap, square; sum register; root stages; output register.
// Throughput: one word per cycle; the pipeline moves as a whole and only halts when the
// output register and the skid register behind it are both full.
// The depth is set by the square root, which resolves one result bit per stage.
// Reset (rst_ni low, asynchronous) empties the pipeline and restores the registers:
// plain mode, 2D, every extent 1.0.
module point_pair_distance_core
  import ppd_pkg::*;
#(
  parameter int unsigned COORD_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [COORD_BITS-1:0] ax_i,
  input  logic [COORD_BITS-1:0] ay_i,
  input  logic [COORD_BITS-1:0] az_i,
  input  logic [COORD_BITS-1:0] bx_i,
  input  logic [COORD_BITS-1:0] by_coord_i,
  input  logic [COORD_BITS-1:0] bz_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic [OUT_W-1:0]      distance_o
);

  localparam int unsigned SQ_W   = 2 * COORD_BITS;
  localparam int unsigned SUM_W  = 2 * COORD_BITS + 2;
  localparam int unsigned ROOT_W = COORD_BITS + 1;
  localparam int unsigned DEPTH  = 4 + ROOT_W;

  logic                  wrap_on_q, three_dims_q;
  logic [COORD_BITS-1:0] x_ext_q, y_ext_q, z_ext_q;

  logic                  adv;
  logic [DEPTH-1:0]      valid_q;
  logic [SQ_W-1:0]       sq_x, sq_y, sq_z;
  logic [SUM_W-1:0]      sum_d, sum_q;
  logic [ROOT_W-1:0]     root;

  logic                  out_v_q, skid_v_q;
  logic [OUT_W-1:0]      out_q, skid_q, last_word;
  logic                  take;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_on_q    <= 1'b0;
      three_dims_q <= 1'b0;
      x_ext_q      <= COORD_BITS'(EXTENT_RESET);
      y_ext_q      <= COORD_BITS'(EXTENT_RESET);
      z_ext_q      <= COORD_BITS'(EXTENT_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WRAP_ON:    wrap_on_q    <= cfg_data_i[0];
        REG_THREE_DIMS: three_dims_q <= cfg_data_i[0];
        REG_X_EXTENT:   x_ext_q      <= cfg_data_i[COORD_BITS-1:0];
        REG_Y_EXTENT:   y_ext_q      <= cfg_data_i[COORD_BITS-1:0];
        REG_Z_EXTENT:   z_ext_q      <= cfg_data_i[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline only halts while the skid register holds a word.
  assign adv     = !skid_v_q;
  assign stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[DEPTH-2:0], valid_i};
    end
  end

  ppd_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .clk_i     (clk_i),
    .en_i      (adv),
    .wrap_on_i (wrap_on_q),
    .extent_i  (x_ext_q),
    .a_i       (ax_i),
    .b_i       (bx_i),
    .square_o  (sq_x)
  );

  ppd_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .clk_i     (clk_i),
    .en_i      (adv),
    .wrap_on_i (wrap_on_q),
    .extent_i  (y_ext_q),
    .a_i       (ay_i),
    .b_i       (by_coord_i),
    .square_o  (sq_y)
  );

  ppd_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
    .clk_i     (clk_i),
    .en_i      (adv),
    .wrap_on_i (wrap_on_q),
    .extent_i  (z_ext_q),
    .a_i       (az_i),
    .b_i       (bz_i),
    .square_o  (sq_z)
  );

  always_comb begin
    sum_d = SUM_W'(sq_x) + SUM_W'(sq_y) + (three_dims_q ? SUM_W'(sq_z) : '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q <= sum_d;
    end
  end

  ppd_sqrt #(.SUM_W(SUM_W), .ROOT_W(ROOT_W)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .sum_i  (sum_q),
    .root_o (root)
  );

  assign last_word = OUT_W'(root);
  assign take      = out_v_q && !stall_i;

  // Output register with a skid register behind it: a word leaving the pipeline
  // while the output is blocked parks in the skid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (valid_q[DEPTH-1]) begin
      if (!out_v_q || take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (valid_q[DEPTH-1]) begin
      if (!out_v_q || take) begin
        out_q <= last_word;
      end else begin
        skid_q <= last_word;
      end
    end
  end

  assign valid_o    = out_v_q;
  assign distance_o = out_q;

endmodule

/* design/ppd_checker.sv */
// Port-level checker for the point pair distance core, bound to the top level.
module ppd_checker
  import ppd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             stall_o,
  input logic             valid_o,
  input logic             stall_i,
  input logic [OUT_W-1:0] distance_o
);

  // The input side is only held off once a result is waiting at the output.
  a_stall_needs_full_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o
  ) else $error("input stalled while the output register is empty");

  // Holding off the input follows a blocked output word in the cycle before.
  a_stall_follows_block: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> $past(valid_o && stall_i)
  ) else $error("input stalled without a blocked output word");

  // Once the output drains, the input is released in the next cycle.
  a_stall_released: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (stall_o && !stall_i) |=> !stall_o
  ) else $error("input stall kept after the output word was taken");

  a_out_held: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(distance_o))
  ) else $error("stalled output word changed or was dropped");

endmodule

bind point_pair_distance_core ppd_checker u_ppd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .stall_o    (stall_o),
  .valid_o    (valid_o),
  .stall_i    (stall_i),
  .distance_o (distance_o)
);
